>>> rtl/core/sst_pkg.sv
package sst_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 6;
    localparam int KIND_W  = 3;
    localparam int ADDR_W  = 3;

    // Reset value of the capacity register
    localparam logic [COUNT_W-1:0] CAP_RESET = 6'd32;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT  = 3'd0,
        KIND_REMOVE  = 3'd1,
        KIND_MEMBER  = 3'd2,
        KIND_RESTART = 3'd3,
        KIND_NEXT    = 3'd4
    } kind_t;

    // Register index of the capacity register
    localparam logic REG_CAPACITY = 1'b0;

    // Shift command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } cell_cmd_t;

endpackage

>>> rtl/core/sst_cell.sv
module sst_cell (
    input  logic                              clk,
    input  sst_pkg::cell_cmd_t                cmd,
    input  logic signed [sst_pkg::DATA_W-1:0] key,
    input  logic                              valid,
    input  logic                              left_lt,
    input  logic signed [sst_pkg::DATA_W-1:0] left_entry,
    input  logic signed [sst_pkg::DATA_W-1:0] right_entry,
    output logic                              lt,
    output logic                              eq,
    output logic signed [sst_pkg::DATA_W-1:0] entry
);
    import sst_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;

    // Compare the held entry against the broadcast key
    assign lt    = valid && (entry_reg < key);
    assign eq    = valid && (entry_reg == key);
    assign entry = entry_reg;

    // Open a gap on insert, close it on remove, from the first cell not below the key
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins && !lt)
        begin
            entry_next = left_lt ? key : left_entry;
        end
        else if (cmd.rem && !lt)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

>>> rtl/core/sorted_set_table.sv
// The result is registered and shows on the master side in the cycle after acceptance.
// Throughput: one request per cycle unless a result stalls; the row of cells compares
// the key in parallel and shifts its entries in the same edge that accepts the request.
// Reset: count, read position and the output valid flag clear, capacity returns to 32;
// the entry cells are not cleared, only cells below the count are ever read.
module sorted_set_table #(
    parameter int DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave side: tdata = value[31:0]; tuser = kind[2:0]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sst_pkg::DATA_W-1:0]    s_tdata,
    input  logic [sst_pkg::KIND_W-1:0]    s_tuser,
    // master side: tdata = ok[0], element[32:1], count[38:33], empty_res[39]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sst_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import sst_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

    logic [COUNT_W-1:0] cap_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      rpos_reg;
    logic [CW-1:0]      rpos_next;
    logic               out_valid_reg;
    logic [39:0]        out_data_reg;
    logic [39:0]        out_data_next;

    logic signed [DATA_W-1:0] key;
    logic [DEPTH-1:0]         cell_lt;
    logic [DEPTH-1:0]         cell_eq;
    logic [DEPTH-1:0]         cell_valid;
    logic signed [DATA_W-1:0] cell_entry [DEPTH];
    cell_cmd_t                cmd;

    logic               accept;
    logic               full;
    logic               found;
    logic               next_ok;
    logic [DATA_W-1:0]  read_data;
    logic               ok;
    logic [DATA_W-1:0]  element;
    logic [COUNT_W-1:0] count_out;

    assign key      = $signed(s_tdata);
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Row of cells, each passing its entry to both neighbours
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign cell_valid[i] = CW'(i) < count_reg;
        sst_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .key         (key),
            .valid       (cell_valid[i]),
            .left_lt     ((i == 0) ? 1'b1 : cell_lt[(i == 0) ? 0 : i-1]),
            .left_entry  (cell_entry[(i == 0) ? 0 : i-1]),
            .right_entry (cell_entry[(i == DEPTH-1) ? i : i+1]),
            .lt          (cell_lt[i]),
            .eq          (cell_eq[i]),
            .entry       (cell_entry[i])
        );
    end

    // Gather the entry under the read position; presence is the OR of the cell matches below
    always_comb
    begin
        read_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (rpos_reg == CW'(i))
            begin
                read_data = read_data | cell_entry[i];
            end
        end
    end

    assign found   = |cell_eq;
    assign full    = (XW'(count_reg) >= XW'(cap_reg)) || (count_reg == CW'(DEPTH));
    assign next_ok = rpos_reg < count_reg;

    // Decode the request
    always_comb
    begin
        cmd        = '0;
        ok         = 1'b0;
        element    = '0;
        count_next = count_reg;
        rpos_next  = rpos_reg;
        unique case (s_tuser)
            KIND_INSERT:
            begin
                ok      = !full;
                cmd.ins = accept && !full && !found;
                if (cmd.ins)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            KIND_REMOVE:
            begin
                ok      = found;
                cmd.rem = accept && found;
                if (cmd.rem)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            KIND_MEMBER:
            begin
                ok = found;
            end
            KIND_RESTART:
            begin
                rpos_next = '0;
            end
            KIND_NEXT:
            begin
                ok = next_ok;
                if (next_ok)
                begin
                    element   = read_data;
                    rpos_next = rpos_reg + CW'(1);
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // Pack the result from the count after the request
    always_comb
    begin
        count_out     = COUNT_W'(count_next);
        out_data_next = {(count_next == '0), count_out, element, ok};
    end

    // Hold state, advance on accepted requests, drop the result once the master side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rpos_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rpos_reg      <= rpos_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY))
        begin
            cap_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? {26'd0, cap_reg} : 32'd0;

endmodule

>>> rtl/core/sst_checker.sv
module sst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // Every accepted request gives a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted request produced no result");

    // Take requests whenever the output stage is free
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("request stalled with empty output stage");

    // Element is zero whenever ok is low
    a_element_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[32:1] == 32'd0))
        else $error("element driven without ok");

    // Hold a stalled result
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind sorted_set_table sst_checker u_sst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
